// ===== design/owo_pkg.sv =====
// Package for the omni wheel odometry block: payload structs, step codes,
// controller commands and fixed-point constants. No dependencies.
package owo_pkg;

  // Default width of the heading accumulator
  localparam int unsigned ANGLE_BITS_DEF = 16;

  // Configuration reset values
  localparam logic [15:0] RADIUS_RST = 16'd2228;
  localparam logic [15:0] OFFSET_RST = 16'd17504;

  // Position after reset, 0.125 m in Q16.16
  localparam logic [31:0] POS_RST = 32'd8192;

  // Fixed-point constants
  localparam logic [31:0] INV_SQRT2  = 32'd46341;      // Q0.16
  localparam logic [31:0] INV_TWO_PI = 32'd683565276;  // Q0.32
  localparam logic [31:0] SIN_C      = 32'd4640;
  localparam logic [16:0] SIN_B      = 17'd42048;
  localparam logic [16:0] SIN_A      = 17'd102944;
  localparam logic [33:0] RECIP3     = 34'd174763;     // ceil(2^19 / 3)
  localparam logic [16:0] QUARTER_Z  = 17'd32768;
  localparam logic [15:0] QUARTER_H  = 16'd16384;
  // Quotient range that divides by three without saturating
  localparam logic signed [23:0] DIV3_HI = 24'sd98304;
  localparam logic signed [23:0] DIV3_LO = -24'sd98304;

  // Dropped-estimate codes
  localparam logic [2:0] DROP_FIRST = 3'd0;
  localparam logic [2:0] DROP_NONE  = 3'd4;

  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WHEEL_RADIUS  = 1'b0,
    REG_OFFSET_FACTOR = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic              mode;
    logic signed [15:0] speed_rear_left;
    logic signed [15:0] speed_front_left;
    logic signed [15:0] speed_front_right;
    logic signed [15:0] speed_rear_right;
    logic [15:0]        step_time;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic [15:0]        load_heading;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] turn_rate;
    logic [2:0]         dropped_estimate;
  } out_t;

  // Datapath steps, in execution order from ST_KL to ST_PY
  typedef enum logic [4:0] {
    ST_LOAD, ST_KL, ST_KR,
    ST_L0, ST_L1, ST_L2, ST_L3, ST_R0, ST_R1,
    ST_KEEP, ST_NEG, ST_VX, ST_VY, ST_VW,
    ST_H0, ST_H1,
    ST_SN0, ST_SN1, ST_SN2, ST_SN3,
    ST_CS0, ST_CS1, ST_CS2, ST_CS3,
    ST_G0, ST_G1, ST_G2, ST_G3,
    ST_PX, ST_PY
  } step_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_RUN,
    CS_OUT
  } ctl_state_e;

  typedef struct packed {
    logic  take;     // latch the input request
    logic  exec;     // run step
    step_e step;
    logic  capture;  // load the output register
  } cmd_t;

endpackage

// ===== design/owo_ctrl.sv =====
// Controller for the omni wheel odometry block: sequences datapath steps
// and owns the request handshakes. Depends on owo_pkg.
module owo_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_mode_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output owo_pkg::cmd_t cmd_o
);

  owo_pkg::ctl_state_e state_q, state_d;
  owo_pkg::step_e      step_q, step_d;
  logic                out_valid_q, out_valid_d;
  logic                slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // Next state and step
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      owo_pkg::CS_IDLE: begin
        if (in_valid_i) begin
          state_d = owo_pkg::CS_RUN;
          step_d  = in_mode_i ? owo_pkg::ST_LOAD : owo_pkg::ST_KL;
        end
      end
      owo_pkg::CS_RUN: begin
        if (step_q == owo_pkg::ST_LOAD || step_q == owo_pkg::ST_PY) begin
          state_d = owo_pkg::CS_OUT;
        end else begin
          step_d = owo_pkg::step_e'(5'(step_q) + 5'd1);
        end
      end
      owo_pkg::CS_OUT: begin
        if (slot_free) begin
          state_d = owo_pkg::CS_IDLE;
        end
      end
      default: begin
        state_d = owo_pkg::CS_IDLE;
      end
    endcase
  end

  // Commands and handshake outputs
  always_comb begin
    in_ready_o    = (state_q == owo_pkg::CS_IDLE);
    cmd_o.take    = (state_q == owo_pkg::CS_IDLE) && in_valid_i;
    cmd_o.exec    = (state_q == owo_pkg::CS_RUN);
    cmd_o.step    = step_q;
    cmd_o.capture = (state_q == owo_pkg::CS_OUT) && slot_free;
    out_valid_d   = cmd_o.capture || (out_valid_q && !out_ready_i);
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= owo_pkg::CS_IDLE;
      step_q      <= owo_pkg::ST_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTH
  a_take_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take |=> state_q == owo_pkg::CS_RUN)
    else $error("accepted request did not start the sequence");
  a_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.exec && (step_q == owo_pkg::ST_PY || step_q == owo_pkg::ST_LOAD))
      |=> state_q == owo_pkg::CS_OUT)
    else $error("sequence did not end after its last step");
  a_capture_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> out_valid_o)
    else $error("captured result not presented");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> !cmd_o.take && !cmd_o.capture)
    else $error("request taken or result captured mid-sequence");
`endif

endmodule

// ===== design/owo_dp.sv =====
// Datapath for the omni wheel odometry block: one shared multiplier, the
// estimate, velocity, heading and position registers. Depends on owo_pkg.
module owo_dp #(
  parameter int unsigned AngleBits = owo_pkg::ANGLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  owo_pkg::cmd_t                   cmd_i,
  input  owo_pkg::in_t                    in_i,
  input  logic                            cfg_valid_i,
  input  logic [owo_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [15:0]                     cfg_data_i,
  output owo_pkg::out_t                   out_o
);

  localparam int unsigned HeadShift = 56 - AngleBits;

  owo_pkg::in_t       in_q;
  owo_pkg::out_t      out_q;
  logic [15:0]        rad_q, ofs_q;
  logic [31:0]        kl_q, kr_q;
  logic signed [32:0] lin_q [4];
  logic signed [36:0] rot_q [2];
  logic signed [38:0] keep_q [3];
  logic signed [23:0] quo_q [3];
  logic               drop_q;
  logic signed [15:0] vel_q [3];
  logic signed [32:0] pv_q;
  logic [AngleBits-1:0] hd_q;
  logic [16:0]        z2_q, t_q;
  logic signed [17:0] sn_q, cs_q;
  logic signed [33:0] gx_q, gy_q;
  logic [31:0]        posx_q, posy_q;

  logic signed [31:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [65:0] prod;

  logic signed [16:0] d_flfr, d_flrl, d_rlrr, d_frrr, s_rlfr, s_flrr;
  logic [AngleBits+15:0] hd_wide;
  logic [AngleBits+15:0] ld_wide;
  logic [15:0]        h16, hc16, hq;
  logic               is_cos;
  logic [16:0]        zraw, zsel;
  logic [1:0]         vidx;
  logic signed [23:0] qsel, usum;
  logic [15:0]        f3;
  logic signed [21:0] q4;
  logic signed [15:0] vel_new;
  logic               drop_new;
  logic [16:0]        s_unsig;

  // Wheel differences and sums
  assign d_flfr = 17'(in_q.speed_front_left) - 17'(in_q.speed_front_right);
  assign d_flrl = 17'(in_q.speed_front_left) - 17'(in_q.speed_rear_left);
  assign d_rlrr = 17'(in_q.speed_rear_left) - 17'(in_q.speed_rear_right);
  assign d_frrr = 17'(in_q.speed_front_right) - 17'(in_q.speed_rear_right);
  assign s_rlfr = 17'(in_q.speed_rear_left) + 17'(in_q.speed_front_right);
  assign s_flrr = 17'(in_q.speed_front_left) + 17'(in_q.speed_rear_right);

  // Heading scaled to and from 16 bits
  assign hd_wide = {hd_q, 16'd0};
  assign h16     = hd_wide[AngleBits+15 -: 16];
  assign ld_wide = {in_q.load_heading, AngleBits'(0)};
  assign hc16    = h16 + owo_pkg::QUARTER_H;

  // Quarter-wave position for sine or cosine
  assign is_cos = (cmd_i.step == owo_pkg::ST_CS0) || (cmd_i.step == owo_pkg::ST_CS1) ||
                  (cmd_i.step == owo_pkg::ST_CS2) || (cmd_i.step == owo_pkg::ST_CS3);
  assign hq     = is_cos ? hc16 : h16;
  assign zraw   = {2'b00, hq[13:0], 1'b0};
  assign zsel   = hq[14] ? (owo_pkg::QUARTER_Z - zraw) : zraw;

  // Velocity component select and division by three
  always_comb begin
    case (cmd_i.step)
      owo_pkg::ST_VY: vidx = 2'd1;
      owo_pkg::ST_VW: vidx = 2'd2;
      default:        vidx = 2'd0;
    endcase
  end
  assign qsel = quo_q[vidx];
  assign usum = qsel - owo_pkg::DIV3_LO;
  assign f3   = prod[34:19];
  assign q4   = 22'(qsel >>> 2);

  always_comb begin
    if (drop_q) begin
      if (qsel >= owo_pkg::DIV3_HI) begin
        vel_new = 16'sh7FFF;
      end else if (qsel < owo_pkg::DIV3_LO) begin
        vel_new = -16'sh8000;
      end else begin
        vel_new = {~f3[15], f3[14:0]};
      end
    end else begin
      if (q4 > 22'sd32767) begin
        vel_new = 16'sh7FFF;
      end else if (q4 < -22'sd32768) begin
        vel_new = -16'sh8000;
      end else begin
        vel_new = q4[15:0];
      end
    end
  end

  // Every subset shows the same deviation, so the first one is dropped
  // whenever the estimates disagree at all
  assign drop_new = (lin_q[0] != lin_q[2]) || (lin_q[1] != lin_q[3]) ||
                    (rot_q[0] != rot_q[1]);

  // Quarter-wave magnitude, up to a full 65536 at the peak
  assign s_unsig = prod[31:15];

  // Shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.step)
      owo_pkg::ST_KL: begin
        mul_a = owo_pkg::INV_SQRT2;
        mul_b = 34'(rad_q);
      end
      owo_pkg::ST_KR: begin
        mul_a = 32'(ofs_q);
        mul_b = 34'(rad_q);
      end
      owo_pkg::ST_L0: begin
        mul_a = 32'(d_flfr);
        mul_b = 34'(kl_q);
      end
      owo_pkg::ST_L1: begin
        mul_a = 32'(d_flrl);
        mul_b = 34'(kl_q);
      end
      owo_pkg::ST_L2: begin
        mul_a = 32'(d_rlrr);
        mul_b = 34'(kl_q);
      end
      owo_pkg::ST_L3: begin
        mul_a = 32'(d_frrr);
        mul_b = 34'(kl_q);
      end
      owo_pkg::ST_R0: begin
        mul_a = 32'(s_rlfr);
        mul_b = 34'(kr_q);
      end
      owo_pkg::ST_R1: begin
        mul_a = 32'(s_flrr);
        mul_b = 34'(kr_q);
      end
      owo_pkg::ST_VX, owo_pkg::ST_VY, owo_pkg::ST_VW: begin
        mul_a = 32'(usum[17:0]);
        mul_b = owo_pkg::RECIP3;
      end
      owo_pkg::ST_H0: begin
        mul_a = 32'(vel_q[2]);
        mul_b = 34'(in_q.step_time);
      end
      owo_pkg::ST_H1: begin
        mul_a = owo_pkg::INV_TWO_PI;
        mul_b = 34'(pv_q);
      end
      owo_pkg::ST_SN0, owo_pkg::ST_CS0: begin
        mul_a = 32'(zsel);
        mul_b = 34'(zsel);
      end
      owo_pkg::ST_SN1, owo_pkg::ST_CS1: begin
        mul_a = owo_pkg::SIN_C;
        mul_b = 34'(z2_q);
      end
      owo_pkg::ST_SN2, owo_pkg::ST_CS2: begin
        mul_a = 32'(t_q);
        mul_b = 34'(z2_q);
      end
      owo_pkg::ST_SN3, owo_pkg::ST_CS3: begin
        mul_a = 32'(t_q);
        mul_b = 34'(zsel);
      end
      owo_pkg::ST_G0: begin
        mul_a = 32'(vel_q[0]);
        mul_b = 34'(cs_q);
      end
      owo_pkg::ST_G1: begin
        mul_a = 32'(vel_q[1]);
        mul_b = 34'(sn_q);
      end
      owo_pkg::ST_G2: begin
        mul_a = 32'(vel_q[0]);
        mul_b = 34'(sn_q);
      end
      owo_pkg::ST_G3: begin
        mul_a = 32'(vel_q[1]);
        mul_b = 34'(cs_q);
      end
      owo_pkg::ST_PX: begin
        mul_a = 32'(in_q.step_time);
        mul_b = gx_q;
      end
      owo_pkg::ST_PY: begin
        mul_a = 32'(in_q.step_time);
        mul_b = gy_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Configuration and pose registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q  <= owo_pkg::RADIUS_RST;
      ofs_q  <= owo_pkg::OFFSET_RST;
      posx_q <= owo_pkg::POS_RST;
      posy_q <= owo_pkg::POS_RST;
      hd_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (owo_pkg::cfg_idx_e'(cfg_index_i))
          owo_pkg::REG_WHEEL_RADIUS:  rad_q <= cfg_data_i;
          owo_pkg::REG_OFFSET_FACTOR: ofs_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.exec) begin
        case (cmd_i.step)
          owo_pkg::ST_LOAD: begin
            posx_q <= in_q.load_x;
            posy_q <= in_q.load_y;
            hd_q   <= ld_wide[AngleBits+15:16];
          end
          owo_pkg::ST_H1: hd_q   <= hd_q + prod[HeadShift +: AngleBits];
          owo_pkg::ST_PX: posx_q <= posx_q + prod[55:24];
          owo_pkg::ST_PY: posy_q <= posy_q + prod[55:24];
          default: ;
        endcase
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      in_q <= in_i;
    end
    if (cmd_i.exec) begin
      case (cmd_i.step)
        owo_pkg::ST_LOAD: begin
          vel_q[0] <= '0;
          vel_q[1] <= '0;
          vel_q[2] <= '0;
          drop_q   <= 1'b0;
        end
        owo_pkg::ST_KL: kl_q     <= prod[31:0];
        owo_pkg::ST_KR: kr_q     <= prod[31:0];
        owo_pkg::ST_L0: lin_q[0] <= prod[48:16];
        owo_pkg::ST_L1: lin_q[1] <= prod[48:16];
        owo_pkg::ST_L2: lin_q[2] <= prod[48:16];
        owo_pkg::ST_L3: lin_q[3] <= prod[48:16];
        owo_pkg::ST_R0: rot_q[0] <= prod[48:12];
        owo_pkg::ST_R1: rot_q[1] <= prod[48:12];
        owo_pkg::ST_KEEP: begin
          // Sum the kept estimates per component
          drop_q    <= drop_new;
          keep_q[0] <= (drop_new ? 39'(lin_q[0]) : 39'(lin_q[0]) <<< 1) +
                       (39'(lin_q[2]) <<< 1);
          keep_q[1] <= (drop_new ? 39'(lin_q[1]) : 39'(lin_q[1]) <<< 1) +
                       (39'(lin_q[3]) <<< 1);
          keep_q[2] <= (drop_new ? 39'(rot_q[0]) : 39'(rot_q[0]) <<< 1) +
                       (39'(rot_q[1]) <<< 1);
        end
        owo_pkg::ST_NEG: begin
          // Negate and take the floor by 65536
          quo_q[0] <= 24'((-40'(keep_q[0])) >>> 16);
          quo_q[1] <= 24'((-40'(keep_q[1])) >>> 16);
          quo_q[2] <= 24'((-40'(keep_q[2])) >>> 16);
        end
        owo_pkg::ST_VX, owo_pkg::ST_VY, owo_pkg::ST_VW: vel_q[vidx] <= vel_new;
        owo_pkg::ST_H0: pv_q <= prod[32:0];
        owo_pkg::ST_SN0, owo_pkg::ST_CS0: z2_q <= prod[31:15];
        owo_pkg::ST_SN1, owo_pkg::ST_CS1: t_q  <= owo_pkg::SIN_B - prod[31:15];
        owo_pkg::ST_SN2, owo_pkg::ST_CS2: t_q  <= owo_pkg::SIN_A - prod[31:15];
        owo_pkg::ST_SN3: sn_q <= hq[15] ? -18'(s_unsig) : 18'(s_unsig);
        owo_pkg::ST_CS3: cs_q <= hq[15] ? -18'(s_unsig) : 18'(s_unsig);
        owo_pkg::ST_G0: gx_q <= prod[33:0];
        owo_pkg::ST_G1: gx_q <= gx_q - prod[33:0];
        owo_pkg::ST_G2: gy_q <= prod[33:0];
        owo_pkg::ST_G3: gy_q <= gy_q + prod[33:0];
        default: ;
      endcase
    end
    if (cmd_i.capture) begin
      out_q.pos_x            <= posx_q;
      out_q.pos_y            <= posy_q;
      out_q.heading          <= h16;
      out_q.vel_x            <= vel_q[0];
      out_q.vel_y            <= vel_q[1];
      out_q.turn_rate        <= vel_q[2];
      out_q.dropped_estimate <= drop_q ? owo_pkg::DROP_FIRST : owo_pkg::DROP_NONE;
    end
  end

  assign out_o = out_q;

endmodule

// ===== design/omni_wheel_odometry.sv =====
// Top level of the omni wheel odometry block: controller plus datapath.
// Depends on owo_pkg, owo_ctrl and owo_dp.
//
//   channel  signals                                   direction
//   in       in_valid_i / in_ready_o / in_i            request in
//   out      out_valid_o / out_ready_i / out_o         result out
//   cfg      cfg_valid_i / cfg_ready_o / cfg_index_i,  register write
//            cfg_data_i
//
// An odometry request runs the 29 steps from ST_KL to ST_PY before its
// result goes to the output register, a set-pose request only ST_LOAD;
// all steps but ST_KEEP and ST_NEG use the single shared multiplier. One
// request is worked on at a time, so a new one is accepted only in idle.
// The next request is taken while the previous result still waits.
// Reset loads the pose (0.125 m, 0.125 m, heading zero) and the registers.
// Register writes are taken in every cycle.
module omni_wheel_odometry #(
  parameter int unsigned AngleBits = owo_pkg::ANGLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  owo_pkg::in_t                  in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output owo_pkg::out_t                 out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [owo_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);

  owo_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  owo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_mode_i   (in_i.mode),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  owo_dp #(
    .AngleBits (AngleBits)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_o       (out_o)
  );

endmodule
